// ===== src/md5_stream_hasher_unit_defines.svh =====
// assertion macros for the md5 stream hasher checker
`ifndef MD5_STREAM_HASHER_UNIT_DEFINES_SVH
`define MD5_STREAM_HASHER_UNIT_DEFINES_SVH

// property checked on every rising clock edge outside of reset
`define MSH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("md5 stream hasher assertion failed");

// property checked on every rising clock edge, reset included
`define MSH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("md5 stream hasher assertion failed during reset");

`endif

// ===== src/md5sh_pkg.sv =====
// shared constants, types and round tables of the md5 stream hasher
package md5sh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RoundW = 6;

  localparam logic [WordW-1:0] Iv0 = 32'h67452301;
  localparam logic [WordW-1:0] Iv1 = 32'hEFCDAB89;
  localparam logic [WordW-1:0] Iv2 = 32'h98BADCFE;
  localparam logic [WordW-1:0] Iv3 = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } md5sh_abcd_t;

  localparam md5sh_abcd_t ChainInit = '{a: Iv0, b: Iv1, c: Iv2, d: Iv3};

  function automatic logic [WordW-1:0] sine_k(input logic [RoundW-1:0] i);
    logic [WordW-1:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // rotate amount depends on the quarter and the round modulo four
  function automatic logic [4:0] rot_s(input logic [RoundW-1:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // message word used by round i
  function automatic logic [3:0] msg_index(input logic [RoundW-1:0] i);
    logic [7:0] t;
    logic [7:0] iw;
    iw = {2'b00, i};
    case (i[5:4])
      2'd0:    t = iw;
      2'd1:    t = iw * 8'd5 + 8'd1;
      2'd2:    t = iw * 8'd3 + 8'd5;
      default: t = iw * 8'd7;
    endcase
    return t[3:0];
  endfunction

endpackage

// ===== src/md5sh_round.sv =====
// one md5 round: boolean function, four-term add, rotate and word shuffle
module md5sh_round import md5sh_pkg::*; (
  input  md5sh_abcd_t       cur_i,
  input  logic [RoundW-1:0] round_i,
  input  logic [WordW-1:0]  msg_i,
  output md5sh_abcd_t       nxt_o
);

  logic [WordW-1:0] f;
  logic [WordW-1:0] sum;
  logic [WordW-1:0] rot;
  logic [4:0]       s;

  always_comb begin
    case (round_i[5:4])
      2'd0:    f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      2'd1:    f = (cur_i.d & cur_i.b) | (~cur_i.d & cur_i.c);
      2'd2:    f = cur_i.b ^ cur_i.c ^ cur_i.d;
      default: f = cur_i.c ^ (cur_i.b | ~cur_i.d);
    endcase
    s   = rot_s(round_i);
    sum = cur_i.a + f + sine_k(round_i) + msg_i;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    nxt_o.a = cur_i.d;
    nxt_o.b = cur_i.b + rot;
    nxt_o.c = cur_i.b;
    nxt_o.d = cur_i.c;
  end

endmodule

// ===== src/md5_stream_hasher_unit.sv =====
// top level of the md5 stream hasher: byte buffer, sequencer and chaining words
//
//  channel | direction | tdata             | tuser        | tlast
//  s_axis  | in        | data_byte [7:0]   | byte_present | end_of_message
//  m_axis  | out       | digest_word[31:0] | -            | final_word
//
// a request without a completing byte goes through accept and decision only
// a byte that fills the 64-byte block adds a pass of 64 rounds and one chaining add
// end of message adds one or two such passes, then four digest words
// async active-low reset restores the md5 initial words and a zero length
// the input is not ready while a block compresses or the digest drains;
// a stalled digest word holds until taken
module md5_stream_hasher_unit import md5sh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SRound = 3'd2;
  localparam logic [2:0] SAdd   = 3'd3;
  localparam logic [2:0] SEmit  = 3'd4;

  // which kind of block the round unit works on
  localparam logic [1:0] PhData = 2'd0;  // full block of message bytes
  localparam logic [1:0] PhPad  = 2'd1;  // padded block without length
  localparam logic [1:0] PhLen  = 2'd2;  // last block carrying the length

  logic [2:0]        state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [RoundW-1:0] round_q, round_d;
  logic [63:0]       total_q, total_d;
  logic [5:0]        fill_q, fill_d;
  logic              mark_q, mark_d;
  logic              present_q, present_d;
  logic              last_q, last_d;
  logic [1:0]        idx_q, idx_d;
  md5sh_abcd_t       chain_q, chain_d;
  md5sh_abcd_t       work_q, work_d;
  md5sh_abcd_t       work_nxt;

  logic [WordW-1:0]  word_q [16];
  logic [3:0]        g;
  logic [WordW-1:0]  raw;
  logic [WordW-1:0]  msg;
  logic [63:0]       bit_len;
  logic              s_acc, m_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = (state_q == SEmit);
  assign m_axis_tlast  = (idx_q == 2'd3);

  always_comb begin
    case (idx_q)
      2'd0:    m_axis_tdata = chain_q.a;
      2'd1:    m_axis_tdata = chain_q.b;
      2'd2:    m_axis_tdata = chain_q.c;
      default: m_axis_tdata = chain_q.d;
    endcase
  end

  // byte writes into the block buffer
  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tuser) begin
      word_q[total_q[5:2]][{total_q[1:0], 3'b000} +: 8] <= s_axis_tdata;
    end
  end

  // message word with padding and length laid over the unwritten bytes
  assign g       = msg_index(round_q);
  assign raw     = word_q[g];
  assign bit_len = {total_q[60:0], 3'b000};

  always_comb begin
    logic [5:0] p;
    p   = '0;
    msg = raw;
    if (phase_q != PhData) begin
      for (int j = 0; j < 4; j++) begin
        p = {g, 2'(j)};
        if (p < fill_q) begin
          msg[8*j +: 8] = raw[8*j +: 8];
        end else if (p == fill_q && mark_q) begin
          msg[8*j +: 8] = PadByte;
        end else begin
          msg[8*j +: 8] = 8'h00;
        end
      end
      if (phase_q == PhLen && g == 4'd14) begin
        msg = bit_len[31:0];
      end else if (phase_q == PhLen && g == 4'd15) begin
        msg = bit_len[63:32];
      end
    end
  end

  md5sh_round u_round (
    .cur_i   (work_q),
    .round_i (round_q),
    .msg_i   (msg),
    .nxt_o   (work_nxt)
  );

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    round_d   = round_q;
    total_d   = total_q;
    fill_d    = fill_q;
    mark_d    = mark_q;
    present_d = present_q;
    last_d    = last_q;
    idx_d     = idx_q;
    chain_d   = chain_q;
    work_d    = work_q;

    if (state_q == SAdd) begin
      chain_d.a = chain_q.a + work_q.a;
      chain_d.b = chain_q.b + work_q.b;
      chain_d.c = chain_q.c + work_q.c;
      chain_d.d = chain_q.d + work_q.d;
    end

    case (state_q)
      SIdle: begin
        if (s_acc) begin
          present_d = s_axis_tuser;
          last_d    = s_axis_tlast;
          if (s_axis_tuser) begin
            total_d = total_q + 64'd1;
          end
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (present_q && total_q[5:0] == 6'd0) begin
          phase_d = PhData;
          work_d  = chain_q;
          round_d = '0;
          state_d = SRound;
        end else if (last_q) begin
          fill_d  = total_q[5:0];
          mark_d  = 1'b1;
          phase_d = (total_q[5:0] >= LenPos) ? PhPad : PhLen;
          work_d  = chain_q;
          round_d = '0;
          state_d = SRound;
        end else begin
          state_d = SIdle;
        end
      end
      SRound: begin
        work_d  = work_nxt;
        round_d = round_q + 1'b1;
        if (round_q == '1) begin
          state_d = SAdd;
        end
      end
      SAdd: begin
        case (phase_q)
          PhData: begin
            if (last_q) begin
              // block just completed, so padding starts at byte zero
              fill_d  = total_q[5:0];
              mark_d  = 1'b1;
              phase_d = PhLen;
              work_d  = chain_d;
              round_d = '0;
              state_d = SRound;
            end else begin
              state_d = SIdle;
            end
          end
          PhPad: begin
            fill_d  = '0;
            mark_d  = 1'b0;
            phase_d = PhLen;
            work_d  = chain_d;
            round_d = '0;
            state_d = SRound;
          end
          default: begin
            idx_d   = '0;
            state_d = SEmit;
          end
        endcase
      end
      SEmit: begin
        if (m_acc) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 2'd3) begin
            chain_d = ChainInit;
            total_d = '0;
            state_d = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      phase_q   <= PhData;
      round_q   <= '0;
      total_q   <= '0;
      present_q <= 1'b0;
      last_q    <= 1'b0;
      idx_q     <= '0;
      chain_q   <= ChainInit;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      round_q   <= round_d;
      total_q   <= total_d;
      present_q <= present_d;
      last_q    <= last_d;
      idx_q     <= idx_d;
      chain_q   <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    mark_q <= mark_d;
    work_q <= work_d;
  end

endmodule

// ===== src/md5sh_checker.sv =====
// port-level checker for the md5 stream hasher and its bind
`include "md5_stream_hasher_unit_defines.svh"

module md5sh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic s_acc, m_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // input side and digest side never open together
  `MSH_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid))
  // every accepted request drops the input ready before the next one is taken
  `MSH_ASSERT(a_busy_after_req, s_acc |=> !s_axis_tready)
  // the final digest word closes the output burst
  `MSH_ASSERT(a_last_closes, (m_acc && m_axis_tlast) |=> !m_axis_tvalid)
  // a stalled digest word holds
  `MSH_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=>
                          (m_axis_tvalid && $stable(m_axis_tdata)))
  // once reset has been seen at an edge, the output is not valid after it
  `MSH_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule

bind md5_stream_hasher_unit md5sh_checker u_md5sh_checker (.*);
